// ===== sv/mrwr_pkg.sv =====
// mrwr_pkg: shared constants for the miller-rabin witness round block
// verdict codes, stream data widths and the default operand width
// no dependencies
package mrwr_pkg;

    localparam int DEFAULT_N_BITS = 32;

    localparam int CAND_BITS    = 32;
    localparam int WIT_BITS     = 32;
    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 8;

    localparam logic [1:0] VC_SMALL_PRIME = 2'd0;
    localparam logic [1:0] VC_TRIVIAL     = 2'd1;
    localparam logic [1:0] VC_PASS        = 2'd2;
    localparam logic [1:0] VC_COMPOSITE   = 2'd3;

endpackage

// ===== sv/mrwr_mulmod.sv =====
// mrwr_mulmod: bit-serial modular multiplier, result = x * y mod m
// scans y msb first, one modular add per cycle: a doubling step and an add step per bit of y
// depends on mrwr_pkg for the default width
module mrwr_mulmod #(
    parameter int N_BITS = mrwr_pkg::DEFAULT_N_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [N_BITS-1:0] x_in,     // must be below m_in
    input  logic [N_BITS-1:0] y_in,
    input  logic [N_BITS-1:0] m_in,
    output logic              done,
    output logic [N_BITS-1:0] result
);

    localparam int CW = $clog2(N_BITS);

    logic [N_BITS-1:0] acc_reg;
    logic [N_BITS-1:0] x_reg;
    logic [N_BITS-1:0] y_reg;
    logic [N_BITS-1:0] m_reg;
    logic [CW-1:0]     cnt_reg;
    logic              phase_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [N_BITS-1:0] op;
    logic [N_BITS-1:0] gap;
    logic              ge;
    logic [N_BITS-1:0] sum;

    // (acc + op) mod m without overflow: op is acc when doubling, x when adding
    always_comb begin
        op  = phase_reg ? x_reg : acc_reg;
        gap = m_reg - op;
        ge  = (acc_reg >= gap);
        sum = ge ? (acc_reg - gap) : (acc_reg + op);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            // pulse after the add step of the last bit
            done_reg <= !start && busy_reg && phase_reg && (cnt_reg == '0);
            if (start) begin
                acc_reg   <= '0;
                x_reg     <= x_in;
                y_reg     <= y_in;
                m_reg     <= m_in;
                cnt_reg   <= CW'(N_BITS - 1);
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (!phase_reg) begin
                    acc_reg   <= sum;
                    phase_reg <= 1'b1;
                end else begin
                    if (y_reg[N_BITS-1]) begin
                        acc_reg <= sum;
                    end
                    y_reg     <= y_reg << 1;
                    phase_reg <= 1'b0;
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

`ifndef SYNTH
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (acc_reg < m_reg))
        else $error("modular product not below modulus");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("done without a preceding run");
`endif

endmodule

// ===== sv/miller_rabin_witness_round.sv =====
// One Miller-Rabin round: takes a candidate n and a witness a, answers with a verdict code
// (0 small prime, 1 trivially not prime, 2 witness passes, 3 composite by witness) and a
// probable-prime flag. Only the low N_BITS bits of both fields are used. One item is worked
// at a time; a finished result sits in an output register, so the next item can be taken
// while it waits. Time per item is set by the shared bit-serial modular multiplier and the
// products it runs: the witness reduction, N_BITS squarings, one product per set bit of the
// odd part t of n-1, and up to s-1 further squarings, plus one strip step per trailing zero
// of n-1. The trivial cases go from the classify state straight to the output, with no
// products at all.
// depends on mrwr_pkg and mrwr_mulmod
module miller_rabin_witness_round #(
    parameter int N_BITS = mrwr_pkg::DEFAULT_N_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mrwr_pkg::S_TDATA_BITS-1:0] s_tdata,  // candidate [31:0], witness [63:32]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mrwr_pkg::M_TDATA_BITS-1:0] m_tdata   // verdict_code [1:0], probable_prime [2]
);

    localparam int W  = N_BITS;
    localparam int CW = $clog2(N_BITS);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLASS   = 4'd1;
    localparam logic [3:0] ST_STRIP   = 4'd2;
    localparam logic [3:0] ST_REDUCE  = 4'd3;
    localparam logic [3:0] ST_SQ      = 4'd4;
    localparam logic [3:0] ST_MUL     = 4'd5;
    localparam logic [3:0] ST_CHECK   = 4'd6;
    localparam logic [3:0] ST_LOOPCHK = 4'd7;
    localparam logic [3:0] ST_LOOP    = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]    state_reg;
    logic [W-1:0]  n_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  ab_reg;
    logic [W-1:0]  nm1_reg;
    logic [W-1:0]  t_reg;
    logic [W-1:0]  x_reg;
    logic [CW-1:0] s_reg;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] bcnt_reg;
    logic [1:0]    code_reg;
    logic          mul_go_reg;
    logic          mul_go_next;
    logic [W-1:0]  opx_reg;
    logic [W-1:0]  opy_reg;
    logic          m_tvalid_reg;
    logic [mrwr_pkg::M_TDATA_BITS-1:0] m_tdata_reg;

    logic          mul_done;
    logic [W-1:0]  mul_res;
    logic          bit_last;
    logic          code_prime;

    mrwr_mulmod #(
        .N_BITS (N_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .x_in    (opx_reg),
        .y_in    (opy_reg),
        .m_in    (n_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign bit_last   = (bcnt_reg == '0);
    assign code_prime = (code_reg == mrwr_pkg::VC_SMALL_PRIME) ||
                        (code_reg == mrwr_pkg::VC_PASS);

    // multiplier launch, registered on the same edge that loads the operands
    always_comb begin
        case (state_reg)
            ST_STRIP:   mul_go_next = t_reg[0];
            ST_REDUCE:  mul_go_next = mul_done;
            ST_SQ:      mul_go_next = mul_done && (t_reg[W-1] || !bit_last);
            ST_MUL:     mul_go_next = mul_done && !bit_last;
            ST_LOOPCHK: mul_go_next = (r_reg < s_reg);
            default:    mul_go_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mul_go_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mul_go_reg <= mul_go_next;
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        n_reg     <= W'(s_tdata[mrwr_pkg::CAND_BITS-1:0]);
                        a_reg     <= W'(s_tdata[mrwr_pkg::S_TDATA_BITS-1:mrwr_pkg::CAND_BITS]);
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    if (n_reg == W'(2) || n_reg == W'(3)) begin
                        code_reg  <= mrwr_pkg::VC_SMALL_PRIME;
                        state_reg <= ST_DONE;
                    end else if (!n_reg[0] || n_reg == W'(1)) begin
                        code_reg  <= mrwr_pkg::VC_TRIVIAL;
                        state_reg <= ST_DONE;
                    end else begin
                        nm1_reg   <= n_reg - W'(1);
                        t_reg     <= n_reg - W'(1);
                        s_reg     <= '0;
                        state_reg <= ST_STRIP;
                    end
                end
                ST_STRIP: begin
                    if (!t_reg[0]) begin
                        t_reg <= t_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        // a mod n as 1 * a mod n
                        opx_reg    <= W'(1);
                        opy_reg    <= a_reg;
                        state_reg  <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (mul_done) begin
                        ab_reg     <= mul_res;
                        x_reg      <= W'(1);
                        bcnt_reg   <= CW'(N_BITS - 1);
                        opx_reg    <= W'(1);
                        opy_reg    <= W'(1);
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (mul_done) begin
                        x_reg <= mul_res;
                        if (t_reg[W-1]) begin
                            opx_reg    <= mul_res;
                            opy_reg    <= ab_reg;
                            state_reg  <= ST_MUL;
                        end else begin
                            t_reg <= t_reg << 1;
                            if (bit_last) begin
                                state_reg <= ST_CHECK;
                            end else begin
                                bcnt_reg   <= bcnt_reg - 1'b1;
                                opx_reg    <= mul_res;
                                opy_reg    <= mul_res;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        x_reg <= mul_res;
                        t_reg <= t_reg << 1;
                        if (bit_last) begin
                            state_reg <= ST_CHECK;
                        end else begin
                            bcnt_reg   <= bcnt_reg - 1'b1;
                            opx_reg    <= mul_res;
                            opy_reg    <= mul_res;
                            state_reg  <= ST_SQ;
                        end
                    end
                end
                ST_CHECK: begin
                    if (x_reg == W'(1) || x_reg == nm1_reg) begin
                        code_reg  <= mrwr_pkg::VC_PASS;
                        state_reg <= ST_DONE;
                    end else begin
                        r_reg     <= CW'(1);
                        state_reg <= ST_LOOPCHK;
                    end
                end
                ST_LOOPCHK: begin
                    if (r_reg < s_reg) begin
                        opx_reg    <= x_reg;
                        opy_reg    <= x_reg;
                        state_reg  <= ST_LOOP;
                    end else begin
                        code_reg  <= mrwr_pkg::VC_COMPOSITE;
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOOP: begin
                    if (mul_done) begin
                        x_reg <= mul_res;
                        // reaching 1 first proves composite, reaching n-1 passes
                        if (mul_res == W'(1)) begin
                            code_reg  <= mrwr_pkg::VC_COMPOSITE;
                            state_reg <= ST_DONE;
                        end else if (mul_res == nm1_reg) begin
                            code_reg  <= mrwr_pkg::VC_PASS;
                            state_reg <= ST_DONE;
                        end else begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= ST_LOOPCHK;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {{(mrwr_pkg::M_TDATA_BITS-3){1'b0}},
                                         code_prime, code_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_flag_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[2] == ((m_tdata_reg[1:0] == mrwr_pkg::VC_SMALL_PRIME) ||
                                             (m_tdata_reg[1:0] == mrwr_pkg::VC_PASS))))
        else $error("probable_prime disagrees with verdict code");

    a_go_in_wait_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_go_reg |-> (state_reg == ST_REDUCE || state_reg == ST_SQ ||
                        state_reg == ST_MUL || state_reg == ST_LOOP))
        else $error("multiplier launched outside a wait state");

    a_residue_below_n: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ || state_reg == ST_MUL || state_reg == ST_LOOP) |->
            (x_reg < n_reg))
        else $error("running residue not below candidate");
`endif

endmodule
